[sv/checksummed_frame_deframer_unit_macros.svh]
// assertion macros for the checksummed frame deframer
// used by the top level only, no other dependencies
`ifndef CHECKSUMMED_FRAME_DEFRAMER_UNIT_MACROS_SVH
`define CHECKSUMMED_FRAME_DEFRAMER_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define CFDU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed");

// next-cycle implication, off during reset
`define CFDU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

[sv/cfdu_pkg.sv]
// shared types and constants for the checksummed frame deframer
// no dependencies
package cfdu_pkg;

  localparam logic [7:0]  HDR_A       = 8'hCA;
  localparam logic [7:0]  HDR_B       = 8'hFE;
  localparam logic [7:0]  TAIL_A      = 8'hEF;
  localparam logic [7:0]  TAIL_B      = 8'hAC;
  localparam logic [15:0] LIMIT_RESET = 16'd260;

  // one-hot parser modes
  typedef enum logic [9:0] {
    MODE_HDR1  = 10'b00_0000_0001,
    MODE_HDR2  = 10'b00_0000_0010,
    MODE_TYPE  = 10'b00_0000_0100,
    MODE_LEN0  = 10'b00_0000_1000,
    MODE_LEN1  = 10'b00_0001_0000,
    MODE_DATA  = 10'b00_0010_0000,
    MODE_SKIP  = 10'b00_0100_0000,
    MODE_SUM   = 10'b00_1000_0000,
    MODE_TAIL1 = 10'b01_0000_0000,
    MODE_TAIL2 = 10'b10_0000_0000
  } mode_t;

  typedef enum logic [2:0] {
    EV_NONE = 3'd0,
    EV_DATA = 3'd1,
    EV_GOOD = 3'd2,
    EV_CSUM = 3'd3,
    EV_TAIL = 3'd4,
    EV_HDR  = 3'd5
  } event_t;

  typedef struct packed {
    event_t      event_res;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [7:0]  frame_type;
    logic [15:0] frame_length;
    logic        too_long;
  } result_t;

endpackage

[sv/cfdu_in_stage.sv]
// input register for received bytes
// depends on nothing but the clock and reset
module cfdu_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       pop,
  output logic       hold_valid,
  output logic [7:0] hold_byte
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;

  // free slot, or the held byte moves on this cycle
  assign in_tready = !valid_r || pop;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
    end
  end

  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

endmodule

[sv/cfdu_parser.sv]
// frame parser state and next-state logic, one byte per advance
// depends on cfdu_pkg
module cfdu_parser
  import cfdu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic [7:0]  rx_byte,
  input  logic [15:0] size_limit,
  output result_t     res
);

  mode_t       mode_r, mode_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        skip_r, skip_nxt;
  logic [15:0] cnt_inc;
  logic [15:0] len_full;
  event_t      ev;
  logic [7:0]  dat;
  logic [15:0] idx;

  assign cnt_inc  = 16'(cnt_r + 16'd1);
  assign len_full = {rx_byte, len_r[7:0]};

  always_comb begin
    mode_nxt = mode_r;
    type_nxt = type_r;
    len_nxt  = len_r;
    cnt_nxt  = cnt_r;
    skip_nxt = skip_r;
    ev       = EV_NONE;
    dat      = 8'd0;
    idx      = 16'd0;
    // checksum byte itself is not summed
    sum_nxt  = (mode_r != MODE_SUM) ? 8'(sum_r + rx_byte) : sum_r;

    case (mode_r)
      MODE_HDR1: begin
        if (rx_byte == HDR_A) begin
          sum_nxt  = HDR_A;
          mode_nxt = MODE_HDR2;
        end
      end
      MODE_HDR2: begin
        if (rx_byte == HDR_A) begin
          sum_nxt = HDR_A;
        end else if (rx_byte == HDR_B) begin
          mode_nxt = MODE_TYPE;
        end else begin
          ev       = EV_HDR;
          mode_nxt = MODE_HDR1;
        end
      end
      MODE_TYPE: begin
        type_nxt = rx_byte;
        mode_nxt = MODE_LEN0;
      end
      MODE_LEN0: begin
        len_nxt  = {8'd0, rx_byte};
        mode_nxt = MODE_LEN1;
      end
      MODE_LEN1: begin
        len_nxt = len_full;
        cnt_nxt = 16'd0;
        if (len_full == 16'd0) begin
          skip_nxt = 1'b0;
          mode_nxt = MODE_SUM;
        end else if (len_full < size_limit) begin
          skip_nxt = 1'b0;
          mode_nxt = MODE_DATA;
        end else begin
          skip_nxt = 1'b1;
          mode_nxt = MODE_SKIP;
        end
      end
      MODE_DATA: begin
        ev      = EV_DATA;
        dat     = rx_byte;
        idx     = cnt_r;
        cnt_nxt = cnt_inc;
        if (cnt_inc == len_r) begin
          mode_nxt = MODE_SUM;
        end
      end
      MODE_SKIP: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc == len_r) begin
          mode_nxt = MODE_SUM;
        end
      end
      MODE_SUM: begin
        if (sum_r == rx_byte) begin
          mode_nxt = MODE_TAIL1;
        end else begin
          ev       = EV_CSUM;
          mode_nxt = MODE_HDR1;
        end
      end
      MODE_TAIL1: begin
        if (rx_byte == TAIL_A) begin
          mode_nxt = MODE_TAIL2;
        end else begin
          ev       = EV_TAIL;
          mode_nxt = MODE_HDR1;
        end
      end
      MODE_TAIL2: begin
        if (rx_byte == TAIL_B) begin
          ev       = EV_GOOD;
          mode_nxt = MODE_HDR2;
        end else begin
          ev       = EV_TAIL;
          mode_nxt = MODE_HDR1;
        end
      end
      default: begin
        mode_nxt = MODE_HDR1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_HDR2;
      sum_r  <= 8'd0;
      type_r <= 8'd0;
      len_r  <= 16'd0;
      cnt_r  <= 16'd0;
      skip_r <= 1'b0;
    end else if (adv) begin
      mode_r <= mode_nxt;
      sum_r  <= sum_nxt;
      type_r <= type_nxt;
      len_r  <= len_nxt;
      cnt_r  <= cnt_nxt;
      skip_r <= skip_nxt;
    end
  end

  // frame fields reflect the state after this byte
  always_comb begin
    res.event_res    = ev;
    res.data_byte    = dat;
    res.byte_index   = idx;
    res.frame_type   = type_nxt;
    res.frame_length = len_nxt;
    res.too_long     = skip_nxt;
  end

endmodule

[sv/cfdu_out_reg.sv]
// result register on the output stream
// depends on cfdu_pkg
module cfdu_out_reg
  import cfdu_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res,
  output logic    free,
  output logic    out_tvalid,
  input  logic    out_tready,
  output result_t held
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign held       = res_r;

endmodule

[sv/checksummed_frame_deframer_unit.sv]
// channel   | dir | payload
// in_*      | in  | tdata[7:0] rx_byte
// out_*     | out | tuser event_res; tdata byte_index, data_byte and frame fields
// cfg_*     | in  | apb register 0 at 0x0: size_limit[15:0]
//
// one byte per cycle sustained while out_tready accepts results; a result passes through the input register
// and then the result register before it shows on out_*, and a stalled output can hold it in between
// reset is synchronous, active low; parser waits for the second header byte, size_limit 260
// a stalled output holds one result and one more byte in the input register
// depends on cfdu_pkg, cfdu_in_stage, cfdu_parser, cfdu_out_reg and the macros header
`include "checksummed_frame_deframer_unit_macros.svh"

module checksummed_frame_deframer_unit
  import cfdu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [7:0] data_byte, [23:8] byte_index, [31:24] frame_type,
                                  // [47:32] frame_length, [48] too_long, [55:49] zero
  output logic [2:0]  out_tuser,  // [2:0] event_res
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic        hold_valid;
  logic [7:0]  hold_byte;
  logic        out_free;
  logic        adv;
  logic [15:0] limit_r;
  logic        data_fields_ok;
  result_t     res;
  result_t     held;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {16'd0, limit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && cfg_paddr[2] == 1'b0) begin
      limit_r <= cfg_pwdata[15:0];
    end
  end

  assign adv = hold_valid && out_free;

  cfdu_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .pop        (adv),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  cfdu_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .rx_byte    (hold_byte),
    .size_limit (limit_r),
    .res        (res)
  );

  cfdu_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (adv),
    .res        (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .held       (held)
  );

  assign out_tuser = held.event_res;
  assign out_tdata = {7'd0, held.too_long, held.frame_length, held.frame_type,
                      held.byte_index, held.data_byte};

  assign data_fields_ok = !held.too_long && (held.byte_index < held.frame_length);

  // payload bytes only come from frames within the limit, and index stays below length
  `CFDU_ASSERT_IMP(a_data_in_range, clk, rst_n, out_tvalid && out_tuser == EV_DATA, data_fields_ok)
  // a byte moving into the parser always lands in the result register
  `CFDU_ASSERT_NXT(a_adv_shows, clk, rst_n, adv, out_tvalid)
  // no event codes above header bad
  `CFDU_ASSERT_IMP(a_event_code, clk, rst_n, out_tvalid, out_tuser <= EV_HDR)

endmodule

[bench/checksummed_frame_deframer_unit_test.sv]
// self-checking bench for checksummed_frame_deframer_unit: byte stream in, events out
// a directed table, then random frame traffic checked against a built-in frame tracker
// depends on cfdu_pkg and the unit's top level
`timescale 1ns / 1ps

module checksummed_frame_deframer_unit_test;
  import cfdu_pkg::*;

  localparam int         CYCLE_LIMIT    = 200000;
  localparam logic [2:0] REG_SIZE_LIMIT = 3'd0;

  typedef enum logic [1:0] {BYTE_LIT, BYTE_SUM, BYTE_BADSUM, SET_LIMIT} step_kind_t;
  typedef enum int {FLAW_NONE, FLAW_HDR, FLAW_SUM, FLAW_TAIL1, FLAW_TAIL2, FLAW_TRUNC} flaw_t;

  typedef struct {
    step_kind_t  kind;
    logic [15:0] value;
    bit          typed;
    event_t      typed_ev;
  } stim_row_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = 8'h00;  // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [55:0] out_tdata;            // [7:0] data_byte, [23:8] byte_index, [31:24] frame_type,
                                     // [47:32] frame_length, [48] too_long
  logic [2:0]  out_tuser;            // [2:0] event_res
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = 3'd0;
  logic [31:0] cfg_pwdata  = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  checksummed_frame_deframer_unit dut (.*);

  always #1 clk = ~clk;

  // frame tracker state
  mode_t       track_mode  = MODE_HDR2;
  logic [7:0]  track_sum   = 8'h00;
  logic [7:0]  track_type  = 8'h00;
  logic [15:0] track_len   = 16'h0000;
  logic [15:0] track_count = 16'h0000;
  logic        track_skip  = 1'b0;
  logic [15:0] track_limit = LIMIT_RESET;

  result_t expected_results[$];
  int      errors        = 0;
  int      cycle_count   = 0;
  int      items_sent    = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;

  stim_row_t directed_rows [36] = '{
    '{BYTE_LIT,    16'h00, 1'b1, EV_HDR},   // bad second header byte straight after reset
    '{BYTE_LIT,    16'h55, 1'b1, EV_NONE},  // junk while hunting for the first header byte
    '{BYTE_LIT,    16'hCA, 1'b0, EV_NONE},
    '{BYTE_LIT,    16'hCA, 1'b0, EV_NONE},  // repeated first header byte restarts
    '{BYTE_LIT,    16'hFE, 1'b0, EV_NONE},
    '{BYTE_LIT,    16'hFF, 1'b0, EV_NONE},
    '{BYTE_LIT,    16'h02, 1'b0, EV_NONE},
    '{BYTE_LIT,    16'h00, 1'b0, EV_NONE},
    '{BYTE_LIT,    16'h00, 1'b0, EV_NONE},
    '{BYTE_LIT,    16'hFF, 1'b0, EV_NONE},
    '{BYTE_SUM,    16'h00, 1'b0, EV_NONE},
    '{BYTE_LIT,    16'hEF, 1'b0, EV_NONE},
    '{BYTE_LIT,    16'hAC, 1'b1, EV_GOOD},
    '{BYTE_LIT,    16'hFE, 1'b0, EV_NONE},  // next frame opens on the second header byte
    '{BYTE_LIT,    16'h00, 1'b0, EV_NONE},
    '{BYTE_LIT,    16'h00, 1'b0, EV_NONE},
    '{BYTE_LIT,    16'h00, 1'b0, EV_NONE},  // zero length
    '{BYTE_BADSUM, 16'h00, 1'b1, EV_CSUM},
    '{BYTE_LIT,    16'hCA, 1'b0, EV_NONE},
    '{BYTE_LIT,    16'hFE, 1'b0, EV_NONE},
    '{BYTE_LIT,    16'h00, 1'b0, EV_NONE},
    '{BYTE_LIT,    16'h00, 1'b0, EV_NONE},
    '{BYTE_LIT,    16'h00, 1'b0, EV_NONE},
    '{BYTE_SUM,    16'h00, 1'b0, EV_NONE},
    '{BYTE_LIT,    16'h00, 1'b1, EV_TAIL},  // wrong first tail byte
    '{SET_LIMIT,   16'h01, 1'b0, EV_NONE},  // every nonzero length now oversize
    '{BYTE_LIT,    16'hCA, 1'b0, EV_NONE},
    '{BYTE_LIT,    16'hFE, 1'b0, EV_NONE},
    '{BYTE_LIT,    16'h5A, 1'b0, EV_NONE},
    '{BYTE_LIT,    16'h02, 1'b0, EV_NONE},
    '{BYTE_LIT,    16'h00, 1'b0, EV_NONE},
    '{BYTE_LIT,    16'h11, 1'b0, EV_NONE},
    '{BYTE_LIT,    16'h22, 1'b0, EV_NONE},
    '{BYTE_SUM,    16'h00, 1'b0, EV_NONE},
    '{BYTE_LIT,    16'hEF, 1'b0, EV_NONE},
    '{BYTE_LIT,    16'h5A, 1'b1, EV_TAIL}   // wrong second tail byte
  };

  task automatic deframe_predict(input logic [7:0] b, output result_t r);
    event_t      ev;
    logic [7:0]  dat;
    logic [15:0] idx;
    ev  = EV_NONE;
    dat = 8'h00;
    idx = 16'h0000;
    // the checksum byte itself is not summed
    if (track_mode != MODE_SUM) track_sum = 8'(track_sum + b);
    case (track_mode)
      MODE_HDR1: begin
        if (b == HDR_A) begin
          track_sum  = HDR_A;
          track_mode = MODE_HDR2;
        end
      end
      MODE_HDR2: begin
        if (b == HDR_A) begin
          track_sum = HDR_A;
        end else if (b == HDR_B) begin
          track_mode = MODE_TYPE;
        end else begin
          ev         = EV_HDR;
          track_mode = MODE_HDR1;
        end
      end
      MODE_TYPE: begin
        track_type = b;
        track_mode = MODE_LEN0;
      end
      MODE_LEN0: begin
        track_len  = {8'h00, b};
        track_mode = MODE_LEN1;
      end
      MODE_LEN1: begin
        track_len   = {b, track_len[7:0]};
        track_count = 16'h0000;
        if (track_len == 16'h0000) begin
          track_skip = 1'b0;
          track_mode = MODE_SUM;
        end else if (track_len < track_limit) begin
          track_skip = 1'b0;
          track_mode = MODE_DATA;
        end else begin
          track_skip = 1'b1;
          track_mode = MODE_SKIP;
        end
      end
      MODE_DATA: begin
        ev          = EV_DATA;
        dat         = b;
        idx         = track_count;
        track_count = track_count + 16'd1;
        if (track_count == track_len) track_mode = MODE_SUM;
      end
      MODE_SKIP: begin
        track_count = track_count + 16'd1;
        if (track_count == track_len) track_mode = MODE_SUM;
      end
      MODE_SUM: begin
        if (track_sum == b) begin
          track_mode = MODE_TAIL1;
        end else begin
          ev         = EV_CSUM;
          track_mode = MODE_HDR1;
        end
      end
      MODE_TAIL1: begin
        if (b == TAIL_A) begin
          track_mode = MODE_TAIL2;
        end else begin
          ev         = EV_TAIL;
          track_mode = MODE_HDR1;
        end
      end
      MODE_TAIL2: begin
        if (b == TAIL_B) begin
          ev         = EV_GOOD;
          track_mode = MODE_HDR2;
        end else begin
          ev         = EV_TAIL;
          track_mode = MODE_HDR1;
        end
      end
      default: track_mode = MODE_HDR1;
    endcase
    r = '{ev, dat, idx, track_type, track_len, track_skip};
  endtask

  // starts and ends at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    items_sent++;
  endtask

  // psel drops at the end before the task returns, which keeps back-to-back transfers apart
  task automatic apb_xfer(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_size_limit(input logic [15:0] v);
    logic [31:0] rd;
    wait_for_results();
    apb_xfer(1'b1, REG_SIZE_LIMIT, {16'h0000, v}, rd);
    apb_xfer(1'b0, REG_SIZE_LIMIT, 32'd0, rd);
    if (rd[15:0] !== v) begin
      $display("%0t size_limit readback: expected %h actual %h", $time, v, rd[15:0]);
      errors++;
    end
    track_limit = v;
  endtask

  task automatic issue_row(input stim_row_t row);
    logic [7:0] b;
    result_t    r;
    if (row.kind == SET_LIMIT) begin
      set_size_limit(row.value);
    end else begin
      case (row.kind)
        BYTE_SUM:    b = track_sum;
        BYTE_BADSUM: b = track_sum ^ (8'h01 << row.value[2:0]);
        default:     b = row.value[7:0];
      endcase
      deframe_predict(b, r);
      if (row.typed) r.event_res = row.typed_ev;
      expected_results.push_back(r);
      send_byte(b);
    end
  endtask

  function automatic stim_row_t lit(input logic [7:0] b);
    return '{BYTE_LIT, {8'h00, b}, 1'b0, EV_NONE};
  endfunction

  // leans on the header bytes and the first tail byte so that they turn up in odd places
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 11))
      0:       return HDR_A;
      1:       return HDR_B;
      2:       return TAIL_A;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] byte_except(input logic [7:0] a, input logic [7:0] c);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == a || b == c);
    return b;
  endfunction

  task automatic gen_frame(input int force_len);
    stim_row_t rows[$];
    int        roll;
    int        len;
    int        cut;
    flaw_t     flaw;
    roll = $urandom_range(0, 99);
    if (roll >= 85 && force_len < 0) begin
      repeat ($urandom_range(1, 6)) rows.push_back(lit(noise_byte()));
    end else begin
      flaw = (roll < 70 || force_len >= 0) ? FLAW_NONE : flaw_t'($urandom_range(1, 5));
      if (force_len >= 0) len = force_len;
      else if (track_limit <= 16) len = $urandom_range(0, track_limit + 1);
      else len = $urandom_range(0, 10);
      // after a good frame the header may open on its second byte
      if (!(track_mode == MODE_HDR2 && $urandom_range(0, 1))) begin
        repeat ($urandom_range(0, 1)) rows.push_back(lit(HDR_A));
        rows.push_back(lit(HDR_A));
      end
      rows.push_back(lit(flaw == FLAW_HDR ? byte_except(HDR_A, HDR_B) : HDR_B));
      rows.push_back(lit(8'($urandom_range(0, 255))));
      rows.push_back(lit(len[7:0]));
      rows.push_back(lit(len[15:8]));
      repeat (len) rows.push_back(lit(noise_byte()));
      if (flaw == FLAW_SUM) begin
        rows.push_back('{BYTE_BADSUM, 16'($urandom_range(0, 7)), 1'b0, EV_NONE});
      end else begin
        rows.push_back('{BYTE_SUM, 16'h0000, 1'b0, EV_NONE});
      end
      rows.push_back(lit(flaw == FLAW_TAIL1 ? byte_except(TAIL_A, TAIL_A) : TAIL_A));
      rows.push_back(lit(flaw == FLAW_TAIL2 ? byte_except(TAIL_B, TAIL_B) : TAIL_B));
      if (flaw == FLAW_TRUNC) begin
        cut  = $urandom_range(1, rows.size() - 1);
        rows = rows[0:cut-1];
      end
    end
    foreach (rows[i]) issue_row(rows[i]);
  endtask

  task automatic random_phase(input logic [15:0] limit, input int spct, input int rpct,
                              input int target, input bit big_first);
    int start;
    set_size_limit(limit);
    send_idle_pct = spct;
    recv_idle_pct = rpct;
    start = items_sent;
    if (big_first) gen_frame(int'(limit));  // length right at the limit, payload skipped
    while (items_sent - start < target) gen_frame(-1);
  endtask

  always @(negedge clk) out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{event_t'(out_tuser), out_tdata[7:0], out_tdata[23:8], out_tdata[31:24],
              out_tdata[47:32], out_tdata[48]};
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result: actual ev %0d data %h idx %0d type %h len %0d long %b",
                 $time, got.event_res, got.data_byte, got.byte_index, got.frame_type,
                 got.frame_length, got.too_long);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          $display("%0t result mismatch: expected ev %0d data %h idx %0d type %h len %0d long %b",
                   $time, want.event_res, want.data_byte, want.byte_index, want.frame_type,
                   want.frame_length, want.too_long);
          $display("%0t                  actual   ev %0d data %h idx %0d type %h len %0d long %b",
                   $time, got.event_res, got.data_byte, got.byte_index, got.frame_type,
                   got.frame_length, got.too_long);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed_rows[i]) issue_row(directed_rows[i]);
    random_phase(LIMIT_RESET, 0, 0, 270, 1'b1);
    random_phase(16'd1, 46, 0, 60, 1'b0);
    random_phase(16'hFFFF, 0, 46, 60, 1'b0);
    random_phase(16'($urandom_range(2, 16)), 12, 12, 60, 1'b0);
    random_phase(16'($urandom_range(1, 65535)), 46, 0, 60, 1'b0);
    random_phase(16'($urandom_range(3, 12)), 0, 46, 60, 1'b0);
    wait_for_results();
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/cfdu_pkg.sv
sv/cfdu_in_stage.sv
sv/cfdu_parser.sv
sv/cfdu_out_reg.sv
sv/checksummed_frame_deframer_unit.sv
bench/checksummed_frame_deframer_unit_test.sv
